FILE: hdl/otsu_threshold_binarizer_macros.svh
// ----------------------------------------------------------------------------
// otsu threshold binarizer assertion macros
// shorthand for clocked implication checks with reset disable
// ----------------------------------------------------------------------------
`ifndef OTSU_THRESHOLD_BINARIZER_MACROS_SVH
`define OTSU_THRESHOLD_BINARIZER_MACROS_SVH

// same-cycle implication
`define OTB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("otb check failed");

// next-cycle implication
`define OTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("otb check failed");

`endif

FILE: hdl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// shared widths, codes and types of the otsu threshold binarizer
// ----------------------------------------------------------------------------
package otb_pkg;

  // frame capacity is 2**MAX_PIXELS_LOG2 pixels
  localparam int unsigned MAX_PIXELS_LOG2 = 22;
  localparam int unsigned CNT_W  = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned SUM_W  = CNT_W + 8;
  localparam int unsigned DIFF_W = SUM_W + CNT_W;
  localparam int unsigned NUM_W  = 2 * DIFF_W;
  localparam int unsigned DEN_W  = 2 * CNT_W;
  localparam int unsigned MA_W   = NUM_W;
  localparam int unsigned MB_W   = DIFF_W;
  localparam int unsigned MP_W   = MA_W + MB_W;

  localparam logic [CNT_W-1:0] PIX_CAP = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // operation codes
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_BINARIZE = 1'b1;

  // result kinds
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_SRCH_INIT,
    ST_SRCH_RD,
    ST_SRCH_ADD,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_MUL_LHS,
    ST_MUL_RHS,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

FILE: hdl/otb_mul.sv
// ----------------------------------------------------------------------------
// otb_mul
// shift-add multiplier, one multiplier bit per cycle, stops early
// ----------------------------------------------------------------------------
module otb_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [otb_pkg::MA_W-1:0]      a_i,
  input  logic [otb_pkg::MB_W-1:0]      b_i,
  output otb_pkg::mul_stat_t            stat_o,
  output logic [otb_pkg::MP_W-1:0]      product_o
);

  logic                     busy_q;
  logic [otb_pkg::MP_W-1:0] acc_q;
  logic [otb_pkg::MP_W-1:0] a_q;
  logic [otb_pkg::MB_W-1:0] b_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= otb_pkg::MP_W'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (b_q == '0);
  assign product_o   = acc_q;

endmodule

FILE: hdl/otsu_threshold_binarizer.sv
// binarize: the result is in the output register the next cycle
// accumulate: a histogram read-modify-write per kept pixel; a dropped one is not stored
// last pixel: a setup state, then per candidate min+1..max-1 a histogram read and add
//   and six shift-add multiplies, then the threshold report
// reset: histogram valid bits, count, min/max and stored threshold clear at once
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// histogram accumulation, exact otsu threshold search and pixel binarization
// ----------------------------------------------------------------------------
`include "otsu_threshold_binarizer_macros.svh"

module otsu_threshold_binarizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       in_operation_i,
  input  logic [7:0] in_pixel_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] out_value_o
);

  localparam int unsigned CW = otb_pkg::CNT_W;
  localparam int unsigned SW = otb_pkg::SUM_W;
  localparam int unsigned DW = otb_pkg::DIFF_W;
  localparam int unsigned NW = otb_pkg::NUM_W;
  localparam int unsigned EW = otb_pkg::DEN_W;
  localparam int unsigned PW = otb_pkg::MP_W;

  otb_pkg::state_e state_q, state_d;

  // frame state
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sum_q;
  logic [7:0]    min_q, max_q;
  logic [7:0]    thr_q;
  logic [255:0]  bin_vld_q;

  // histogram memory
  logic [CW-1:0] hist_mem [256];
  logic [CW-1:0] hist_rd_q;
  logic [7:0]    hist_addr_q;
  logic          mem_rd_en;
  logic [7:0]    mem_rd_addr;
  logic          mem_wr_en;
  logic [CW-1:0] hist_val;

  // latched item
  logic [7:0] px_q;
  logic       last_q;

  // search state
  logic [8:0]    t_q;
  logic [CW-1:0] nf_q;
  logic [SW-1:0] sf_q;
  logic [DW-1:0] c_q, diff_q;
  logic [NW-1:0] num_q, best_num_q;
  logic [EW-1:0] den_q, best_den_q;
  logic [PW-1:0] lhs_q;
  logic [7:0]    best_t_q;
  logic [DW:0]   diff_full;
  logic [DW:0]   diff_abs;
  logic          t_more;

  // multiplier
  logic                   mul_issued_q;
  logic                   mul_state;
  logic                   mul_start;
  logic [otb_pkg::MA_W-1:0] mul_a;
  logic [otb_pkg::MB_W-1:0] mul_b;
  otb_pkg::mul_stat_t     mul_stat;
  logic [PW-1:0]          mul_p;

  // output register
  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_value_q;
  logic       out_free;
  logic       in_xfer;
  logic       acc_take;
  logic       rpt_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == otb_pkg::ST_IDLE) && out_free);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign acc_take = in_xfer && (in_operation_i == otb_pkg::OP_ACCUM) &&
                    (cnt_q < otb_pkg::PIX_CAP);
  assign hist_val = bin_vld_q[hist_addr_q] ? hist_rd_q : '0;
  assign diff_full = {1'b0, c_q} - {1'b0, mul_p[DW-1:0]};
  assign diff_abs = diff_full[DW] ? (~diff_full + 1'b1) : diff_full;
  assign t_more = (t_q + 9'd1) < {1'b0, max_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otb_pkg::ST_IDLE: begin
        if (in_xfer && (in_operation_i == otb_pkg::OP_ACCUM)) begin
          if (acc_take) begin
            state_d = otb_pkg::ST_ACC_WR;
          end else if (in_last_i) begin
            state_d = otb_pkg::ST_SRCH_INIT;
          end
        end
      end
      otb_pkg::ST_ACC_WR: begin
        state_d = last_q ? otb_pkg::ST_SRCH_INIT : otb_pkg::ST_IDLE;
      end
      otb_pkg::ST_SRCH_INIT: begin
        state_d = (({1'b0, min_q} + 9'd1) < {1'b0, max_q}) ? otb_pkg::ST_SRCH_RD
                                                           : otb_pkg::ST_FINISH;
      end
      otb_pkg::ST_SRCH_RD:  state_d = otb_pkg::ST_SRCH_ADD;
      otb_pkg::ST_SRCH_ADD: state_d = otb_pkg::ST_MUL_C;
      otb_pkg::ST_MUL_C:    if (mul_stat.done) state_d = otb_pkg::ST_MUL_D;
      otb_pkg::ST_MUL_D:    if (mul_stat.done) state_d = otb_pkg::ST_MUL_NUM;
      otb_pkg::ST_MUL_NUM:  if (mul_stat.done) state_d = otb_pkg::ST_MUL_DEN;
      otb_pkg::ST_MUL_DEN:  if (mul_stat.done) state_d = otb_pkg::ST_MUL_LHS;
      otb_pkg::ST_MUL_LHS:  if (mul_stat.done) state_d = otb_pkg::ST_MUL_RHS;
      otb_pkg::ST_MUL_RHS: begin
        if (mul_stat.done) begin
          state_d = t_more ? otb_pkg::ST_SRCH_RD : otb_pkg::ST_FINISH;
        end
      end
      otb_pkg::ST_FINISH: begin
        if (out_free) state_d = otb_pkg::ST_IDLE;
      end
      default: state_d = otb_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = in_pixel_i;
    mem_wr_en   = 1'b0;
    mul_state   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rpt_load    = 1'b0;
    unique case (state_q)
      otb_pkg::ST_IDLE: mem_rd_en = acc_take;
      otb_pkg::ST_ACC_WR: mem_wr_en = 1'b1;
      otb_pkg::ST_SRCH_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = t_q[7:0] - 8'd1;
      end
      otb_pkg::ST_MUL_C: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(sum_q);
        mul_b     = otb_pkg::MB_W'(nf_q);
      end
      otb_pkg::ST_MUL_D: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(sf_q);
        mul_b     = otb_pkg::MB_W'(cnt_q);
      end
      otb_pkg::ST_MUL_NUM: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(diff_q);
        mul_b     = otb_pkg::MB_W'(diff_q);
      end
      otb_pkg::ST_MUL_DEN: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(nf_q);
        mul_b     = otb_pkg::MB_W'(cnt_q - nf_q);
      end
      otb_pkg::ST_MUL_LHS: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(num_q);
        mul_b     = otb_pkg::MB_W'(best_den_q);
      end
      otb_pkg::ST_MUL_RHS: begin
        mul_state = 1'b1;
        mul_a     = otb_pkg::MA_W'(best_num_q);
        mul_b     = otb_pkg::MB_W'(den_q);
      end
      otb_pkg::ST_FINISH: rpt_load = out_free;
      default: ;
    endcase
  end

  assign mul_start = mul_state && !mul_issued_q;

  otb_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .stat_o    (mul_stat),
    .product_o (mul_p)
  );

  // histogram memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      hist_mem[px_q] <= hist_val + 1'b1;
    end
    if (mem_rd_en) begin
      hist_rd_q   <= hist_mem[mem_rd_addr];
      hist_addr_q <= mem_rd_addr;
    end
  end

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= otb_pkg::ST_IDLE;
      cnt_q        <= '0;
      sum_q        <= '0;
      min_q        <= otb_pkg::LEVEL_MAX;
      max_q        <= '0;
      thr_q        <= '0;
      bin_vld_q    <= '0;
      mul_issued_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start) begin
        mul_issued_q <= 1'b1;
      end else if (mul_stat.done) begin
        mul_issued_q <= 1'b0;
      end
      // frame statistics on each kept pixel
      if (acc_take) begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q + SW'(in_pixel_i);
        if (in_pixel_i < min_q) min_q <= in_pixel_i;
        if (in_pixel_i > max_q) max_q <= in_pixel_i;
      end
      if (mem_wr_en) begin
        bin_vld_q[px_q] <= 1'b1;
      end
      // report and frame clear
      if (rpt_load) begin
        thr_q     <= best_t_q;
        cnt_q     <= '0;
        sum_q     <= '0;
        min_q     <= otb_pkg::LEVEL_MAX;
        max_q     <= '0;
        bin_vld_q <= '0;
      end
      // output register
      if (rpt_load || (in_xfer && (in_operation_i == otb_pkg::OP_BINARIZE))) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q   <= in_pixel_i;
      last_q <= in_last_i;
    end
    if (rpt_load) begin
      out_kind_q  <= otb_pkg::KIND_REPORT;
      out_value_q <= best_t_q;
    end else if (in_xfer && (in_operation_i == otb_pkg::OP_BINARIZE)) begin
      out_kind_q  <= otb_pkg::KIND_PIXEL;
      out_value_q <= (in_pixel_i >= thr_q) ? otb_pkg::LEVEL_MAX : 8'd0;
    end
    // search datapath
    case (state_q)
      otb_pkg::ST_SRCH_INIT: begin
        t_q        <= {1'b0, min_q} + 9'd1;
        nf_q       <= '0;
        sf_q       <= '0;
        best_t_q   <= '0;
        best_num_q <= '0;
        best_den_q <= EW'(1);
      end
      otb_pkg::ST_SRCH_ADD: begin
        nf_q <= nf_q + hist_val;
        sf_q <= sf_q + SW'(hist_addr_q) * SW'(hist_val);
      end
      otb_pkg::ST_MUL_C:   if (mul_stat.done) c_q <= mul_p[DW-1:0];
      otb_pkg::ST_MUL_D:   if (mul_stat.done) diff_q <= diff_abs[DW-1:0];
      otb_pkg::ST_MUL_NUM: if (mul_stat.done) num_q <= mul_p[NW-1:0];
      otb_pkg::ST_MUL_DEN: if (mul_stat.done) den_q <= mul_p[EW-1:0];
      otb_pkg::ST_MUL_LHS: if (mul_stat.done) lhs_q <= mul_p;
      otb_pkg::ST_MUL_RHS: begin
        if (mul_stat.done) begin
          if (lhs_q > mul_p) begin
            best_num_q <= num_q;
            best_den_q <= den_q;
            best_t_q   <= t_q[7:0];
          end
          t_q <= t_q + 9'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;

  // checks
  `OTB_ASSERT_SAME(a_cnt_cap, 1'b1, cnt_q <= otb_pkg::PIX_CAP)
  `OTB_ASSERT_SAME(a_mul_no_restart, mul_start, !mul_stat.busy)
  `OTB_ASSERT_NEXT(a_rpt_out, rpt_load,
    out_valid_o && (out_kind_o == otb_pkg::KIND_REPORT) && (out_value_o == thr_q))
  `OTB_ASSERT_NEXT(a_rpt_clear, rpt_load, (cnt_q == '0) && (bin_vld_q == '0))

endmodule
